[src/pn3d_pkg.sv]
// shared constants for the 3d perlin noise block
`default_nettype none
package pn3d_pkg;

  // permutation table geometry
  localparam int PN3D_TABLE_SIZE = 256;
  localparam int PN3D_IDX_W      = $clog2(PN3D_TABLE_SIZE);

  // default fraction width of the coordinates
  localparam int PN3D_FRAC_BITS  = 16;

  // gradient selection codes taken from the low hash nibble
  localparam logic [3:0] GRAD_U_IS_Y_MIN = 4'd8;
  localparam logic [3:0] GRAD_V_IS_Y_MAX = 4'd4;
  localparam logic [3:0] GRAD_V_IS_X_A   = 4'd12;
  localparam logic [3:0] GRAD_V_IS_X_B   = 4'd14;

endpackage
`default_nettype wire

[src/pn3d_ram.sv]
// generic single write port ram with one registered read port
`default_nettype none
module pn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/perlin_noise_3d.sv]
// 3d improved perlin noise, eight stage pipeline with replicated permutation tables
// an accepted beat passes through the stage registers in order and then into the output register
// throughput: one beat per cycle; the pipeline advances unless the output is held
// the three hash levels read 2, 4 and 8 private table copies, written in item order
// reset clears all valid bits; table contents are undefined until written, no clear pass
`default_nettype none
module perlin_noise_3d #(
  parameter int FRACTION_BITS = pn3d_pkg::PN3D_FRAC_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            func_i,
  input  wire logic signed [31:0]              x_coord_i,
  input  wire logic signed [31:0]              y_coord_i,
  input  wire logic signed [31:0]              z_coord_i,
  input  wire logic [pn3d_pkg::PN3D_IDX_W-1:0] table_index_i,
  input  wire logic [pn3d_pkg::PN3D_IDX_W-1:0] table_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [16:0]                     noise_value_o
);
  import pn3d_pkg::*;

  localparam int FB  = FRACTION_BITS;
  localparam int IW  = PN3D_IDX_W;
  localparam int CW  = FB + 2;   // signed corner offset
  localparam int GW  = FB + 3;   // signed gradient and blend values
  localparam int PW  = FB + 5;   // fade polynomial term
  localparam int SH  = FB + 1 - 16;
  localparam int POS_SH = (SH > 0) ? SH : 0;
  localparam int NEG_SH = (SH < 0) ? -SH : 0;
  localparam int RW  = FB + 18;

  localparam logic [CW-1:0] ONE_C  = CW'(1) << FB;
  localparam logic [GW:0]   ONE_M  = (GW+1)'(1) << FB;
  localparam logic [FB+1:0] TWO_M  = (FB+2)'(2) << FB;
  localparam logic [FB:0]   ONE_F  = (FB+1)'(1) << FB;

  // gradient dot product for one corner
  function automatic logic signed [GW-1:0] grad(input logic [IW-1:0] hash,
      input logic signed [CW-1:0] gx, input logic signed [CW-1:0] gy,
      input logic signed [CW-1:0] gz);
    logic [3:0] h;
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    h  = hash[3:0];
    gu = (h < GRAD_U_IS_Y_MIN) ? GW'(gx) : GW'(gy);
    if (h < GRAD_V_IS_Y_MAX) begin
      gv = GW'(gy);
    end else if (h == GRAD_V_IS_X_A || h == GRAD_V_IS_X_B) begin
      gv = GW'(gx);
    end else begin
      gv = GW'(gz);
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  // a + floor((b - a) * t)
  function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] la,
      input logic signed [GW-1:0] lb, input logic [FB:0] t);
    logic signed [GW:0]      df;
    logic signed [GW+FB+2:0] pr;
    df = (GW+1)'(lb) - (GW+1)'(la);
    pr = df * $signed({1'b0, t});
    return la + $signed(pr[GW+FB-1:FB]);
  endfunction

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage valid and func flags
  logic [7:1] vld_q;
  logic [7:1] fn_q;

  // stage payloads
  logic [IW-1:0]  idx1_q, val1_q, idx2_q, val2_q;
  logic [IW-1:0]  cy1_q, cz1_q, cz2_q;
  logic [FB-1:0]  frac1_q [3];
  logic [FB-1:0]  frac2_q [3];
  logic [FB-1:0]  frac3_q [3];
  logic [FB-1:0]  sq2_q   [3];
  logic [FB-1:0]  cube3_q [3];
  logic [PW-1:0]  poly3_q [3];
  logic [FB:0]    fade4_q [3];
  logic [FB:0]    fv5_q, fw5_q, fw6_q;
  logic signed [GW-1:0] g4_q [8];
  logic signed [GW-1:0] x5_q [4];
  logic signed [GW-1:0] y6_q [2];
  logic signed [GW-1:0] n7_q;
  logic [16:0]    noise_q;
  logic           out_vld_q;

  // table read data per level
  logic [IW-1:0]  p1 [2];
  logic [IW-1:0]  p2 [4];
  logic [IW-1:0]  h3 [8];

  // next values
  logic [FB-1:0]  sq_d   [3];
  logic [FB-1:0]  cube_d [3];
  logic [PW-1:0]  poly_d [3];
  logic [FB:0]    fade_d [3];
  logic signed [GW-1:0] g_d [8];
  logic signed [GW-1:0] x_d [4];
  logic signed [GW-1:0] y_d [2];
  logic signed [GW-1:0] n_d;
  logic [16:0]    noise_d;
  logic [IW-1:0]  l1_addr [2];
  logic [IW-1:0]  l2_addr [4];
  logic [IW-1:0]  l3_addr [8];
  logic [FB-1:0]  frac_in [3];

  assign frac_in[0] = x_coord_i[FB-1:0];
  assign frac_in[1] = y_coord_i[FB-1:0];
  assign frac_in[2] = z_coord_i[FB-1:0];
  assign l1_addr[0] = x_coord_i[FB+IW-1:FB];
  assign l1_addr[1] = x_coord_i[FB+IW-1:FB] + IW'(1);

  // level one hash: perm(cx), perm(cx+1)
  for (genvar k = 0; k < 2; k++) begin : g_l1
    pn3d_ram #(.WIDTH(IW), .DEPTH(PN3D_TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (in_valid_i && adv && !func_i),
      .waddr_i (table_index_i),
      .wdata_i (table_value_i),
      .re_i    (adv),
      .raddr_i (l1_addr[k]),
      .rdata_o (p1[k])
    );
  end

  // stage 1: square of fractions, level two addresses
  always_comb begin
    logic [2*FB-1:0] pr;
    for (int k = 0; k < 3; k++) begin
      pr       = frac1_q[k] * frac1_q[k];
      sq_d[k]  = pr[2*FB-1:FB];
    end
    l2_addr[0] = p1[0] + cy1_q;
    l2_addr[1] = p1[0] + cy1_q + IW'(1);
    l2_addr[2] = p1[1] + cy1_q;
    l2_addr[3] = p1[1] + cy1_q + IW'(1);
  end

  for (genvar k = 0; k < 4; k++) begin : g_l2
    pn3d_ram #(.WIDTH(IW), .DEPTH(PN3D_TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (vld_q[1] && adv && !fn_q[1]),
      .waddr_i (idx1_q),
      .wdata_i (val1_q),
      .re_i    (adv),
      .raddr_i (l2_addr[k]),
      .rdata_o (p2[k])
    );
  end

  // stage 2: cube and fade polynomial, level three addresses
  always_comb begin
    logic [2*FB-1:0] pr;
    logic signed [FB+5:0] pt;
    for (int k = 0; k < 3; k++) begin
      pr         = sq2_q[k] * frac2_q[k];
      cube_d[k]  = pr[2*FB-1:FB];
      pt         = (FB+6)'(6) * $signed({6'd0, sq2_q[k]})
                 + ((FB+6)'(10) << FB)
                 - (FB+6)'(15) * $signed({6'd0, frac2_q[k]});
      poly_d[k]  = (pt < 0) ? '0 : pt[PW-1:0];
    end
    // corners ordered aa, ba, ab, bb, then the same plus one
    l3_addr[0] = p2[0] + cz2_q;
    l3_addr[1] = p2[2] + cz2_q;
    l3_addr[2] = p2[1] + cz2_q;
    l3_addr[3] = p2[3] + cz2_q;
    for (int k = 0; k < 4; k++) begin
      l3_addr[k+4] = l3_addr[k] + IW'(1);
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_l3
    pn3d_ram #(.WIDTH(IW), .DEPTH(PN3D_TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (vld_q[2] && adv && !fn_q[2]),
      .waddr_i (idx2_q),
      .wdata_i (val2_q),
      .re_i    (adv),
      .raddr_i (l3_addr[k]),
      .rdata_o (h3[k])
    );
  end

  // stage 3: fade values and corner gradients
  always_comb begin
    logic [2*FB+4:0] pr;
    logic [PW-1:0]   fs;
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
    for (int k = 0; k < 3; k++) begin
      pr        = cube3_q[k] * poly3_q[k];
      fs        = pr[2*FB+4:FB];
      fade_d[k] = (fs > PW'(ONE_F)) ? ONE_F : fs[FB:0];
      lo[k]     = $signed({2'b00, frac3_q[k]});
      hi[k]     = $signed({2'b00, frac3_q[k]} - ONE_C);
    end
    g_d[0] = grad(h3[0], lo[0], lo[1], lo[2]);
    g_d[1] = grad(h3[1], hi[0], lo[1], lo[2]);
    g_d[2] = grad(h3[2], lo[0], hi[1], lo[2]);
    g_d[3] = grad(h3[3], hi[0], hi[1], lo[2]);
    g_d[4] = grad(h3[4], lo[0], lo[1], hi[2]);
    g_d[5] = grad(h3[5], hi[0], lo[1], hi[2]);
    g_d[6] = grad(h3[6], lo[0], hi[1], hi[2]);
    g_d[7] = grad(h3[7], hi[0], hi[1], hi[2]);
  end

  // stages 4 to 6: blend along x, y, then z
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      x_d[k] = lerp(g4_q[2*k], g4_q[2*k+1], fade4_q[0]);
    end
    y_d[0] = lerp(x5_q[0], x5_q[1], fv5_q);
    y_d[1] = lerp(x5_q[2], x5_q[3], fv5_q);
    n_d    = lerp(y6_q[0], y6_q[1], fw6_q);
  end

  // stage 7: map to 0..1 and scale to the output format
  always_comb begin
    logic signed [GW:0] m;
    logic [FB+1:0]      mc;
    logic [RW-1:0]      rw;
    m = (GW+1)'(n7_q) + ONE_M;
    if (m < 0) begin
      mc = '0;
    end else if (m > $signed({1'b0, (GW)'(TWO_M)})) begin
      mc = TWO_M;
    end else begin
      mc = m[FB+1:0];
    end
    rw      = (RW'(mc) << NEG_SH) >> POS_SH;
    noise_d = (rw > RW'(65536)) ? 17'd65536 : rw[16:0];
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[6:1], in_valid_i};
      out_vld_q <= vld_q[7] && fn_q[7];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fn_q    <= {fn_q[6:1], func_i};
      idx1_q  <= table_index_i;
      val1_q  <= table_value_i;
      cy1_q   <= y_coord_i[FB+IW-1:FB];
      cz1_q   <= z_coord_i[FB+IW-1:FB];
      idx2_q  <= idx1_q;
      val2_q  <= val1_q;
      cz2_q   <= cz1_q;
      for (int k = 0; k < 3; k++) begin
        frac1_q[k] <= frac_in[k];
        frac2_q[k] <= frac1_q[k];
        frac3_q[k] <= frac2_q[k];
        sq2_q[k]   <= sq_d[k];
        cube3_q[k] <= cube_d[k];
        poly3_q[k] <= poly_d[k];
        fade4_q[k] <= fade_d[k];
      end
      for (int k = 0; k < 8; k++) g4_q[k] <= g_d[k];
      for (int k = 0; k < 4; k++) x5_q[k] <= x_d[k];
      fv5_q   <= fade4_q[1];
      fw5_q   <= fade4_q[2];
      y6_q[0] <= y_d[0];
      y6_q[1] <= y_d[1];
      fw6_q   <= fw5_q;
      n7_q    <= n_d;
      noise_q <= noise_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign noise_value_o = noise_q;

endmodule
`default_nettype wire
